// ----- rtl/core/dpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drum pad trigger package
// Payload types, register indexes and MIDI constants shared by the trigger
// core.
// ----------------------------------------------------------------------------
package dpt_pkg;

    typedef struct packed {
        logic [2:0] pad;
        logic [9:0] sample;
    } dpt_in_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] note;
        logic [6:0] velocity;
    } dpt_out_t;

    // Per-pad state word kept in the state memory
    typedef struct packed {
        logic        active;
        logic [15:0] count;
    } dpt_state_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_TABLE    = 3'd4;

    localparam logic [9:0]  THRESHOLD_RST     = 10'd70;
    localparam logic [15:0] HOLD_TICKS_RST    = 16'd100;
    localparam logic        VELOCITY_MODE_RST = 1'b0;
    localparam logic [3:0]  MIDI_CHANNEL_RST  = 4'd1;
    localparam logic [47:0] NOTE_TABLE_RST    = 48'h322A282D2B29;

    localparam logic [7:0]  NOTE_ON_STATUS = 8'd144;
    localparam logic [6:0]  FIXED_VELOCITY = 7'd127;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

endpackage
`default_nettype wire

// ----- rtl/core/drum_pad_trigger_to_midi.sv -----
// A note-on passes from the accept stage through the update stage registers into the output
// queue, and is valid at the output once it has been written there.
// Accepts one sample per cycle while in_ready is high; the state memory is read at accept and
// written back from the update stage, with forwarding for back-to-back hits on a pad.
// Results wait in a three-entry output queue; input stalls once the queued note-ons plus any
// sample in the update stage reach three.
// Reset: asynchronous, clears all pads to idle with zero count via valid bits.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drum pad trigger to MIDI note-on
// Tracks an active flag and hold counter per pad in a small state memory and
// emits a note-on transaction when a pad is hit while idle.
// ----------------------------------------------------------------------------
module drum_pad_trigger_to_midi #(
    parameter int unsigned PADS = 6
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire [dpt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [dpt_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  dpt_pkg::dpt_in_t                    in_data,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output dpt_pkg::dpt_out_t                   out_data
);
    import dpt_pkg::*;

    localparam int unsigned PAD_W      = (PADS > 1) ? $clog2(PADS) : 1;
    localparam int unsigned FIFO_DEPTH = 3;
    localparam int unsigned FIFO_PW    = 2;

    // Configuration registers
    logic [9:0]  threshold_reg;
    logic [15:0] hold_ticks_reg;
    logic        velocity_mode_reg;
    logic [3:0]  midi_channel_reg;
    logic [47:0] note_table_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= THRESHOLD_RST;
            hold_ticks_reg    <= HOLD_TICKS_RST;
            velocity_mode_reg <= VELOCITY_MODE_RST;
            midi_channel_reg  <= MIDI_CHANNEL_RST;
            note_table_reg    <= NOTE_TABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:     threshold_reg     <= cfg_wdata[9:0];
                REG_HOLD_TICKS:    hold_ticks_reg    <= cfg_wdata[15:0];
                REG_VELOCITY_MODE: velocity_mode_reg <= cfg_wdata[0];
                REG_MIDI_CHANNEL:  midi_channel_reg  <= cfg_wdata[3:0];
                REG_NOTE_TABLE:    note_table_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accept stage: read the pad's state
    logic             in_accept;
    logic             in_range;
    logic [PAD_W-1:0] in_idx;
    logic             rd_en;

    assign in_accept = in_valid && in_ready;
    assign in_range  = {29'd0, in_data.pad} < PADS;
    assign in_idx    = in_data.pad[PAD_W-1:0];
    assign rd_en     = in_accept && in_range;

    dpt_state_t       state_mem [PADS];
    logic [PADS-1:0]  vld_reg;
    dpt_state_t       rd_data_reg;
    logic             rd_vld_reg;

    logic             s1_vld_reg;
    logic [PAD_W-1:0] s1_idx_reg;
    logic [9:0]       s1_sample_reg;

    // Write-back of the update stage, registered for forwarding
    logic             fwd_vld_reg;
    logic [PAD_W-1:0] fwd_idx_reg;
    dpt_state_t       fwd_data_reg;

    dpt_state_t       cur_state;
    dpt_state_t       new_state;
    logic [15:0]      count_inc;
    logic             hit;
    logic             emit;
    logic [6:0]       vel_div;
    dpt_out_t         result;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg   <= state_mem[in_idx];
            rd_vld_reg    <= vld_reg[in_idx];
            s1_idx_reg    <= in_idx;
            s1_sample_reg <= in_data.sample;
        end
        if (s1_vld_reg)
        begin
            state_mem[s1_idx_reg] <= new_state;
        end
        fwd_idx_reg  <= s1_idx_reg;
        fwd_data_reg <= new_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            s1_vld_reg  <= rd_en;
            fwd_vld_reg <= s1_vld_reg;
            if (s1_vld_reg)
            begin
                vld_reg[s1_idx_reg] <= 1'b1;
            end
        end
    end

    // Update stage: pick the freshest state, then apply the trigger rules
    always_comb
    begin
        if (fwd_vld_reg && (fwd_idx_reg == s1_idx_reg))
        begin
            cur_state = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_state = rd_data_reg;
        end
        else
        begin
            cur_state = '0;
        end

        count_inc = (cur_state.count == COUNT_MAX) ? cur_state.count
                                                   : cur_state.count + 16'd1;
        hit       = s1_sample_reg > threshold_reg;
        emit      = s1_vld_reg && hit && !cur_state.active;
        new_state = cur_state;

        if (hit)
        begin
            if (!cur_state.active)
            begin
                new_state.active = 1'b1;
                new_state.count  = '0;
            end
            else
            begin
                new_state.count = count_inc;
            end
        end
        else if (cur_state.active)
        begin
            new_state.count  = count_inc;
            new_state.active = !(count_inc > hold_ticks_reg);
        end
    end

    always_comb
    begin
        vel_div            = s1_sample_reg[9:3];
        result.status_byte = NOTE_ON_STATUS + {4'd0, midi_channel_reg};
        result.note        = note_table_reg[{s1_idx_reg, 3'b000} +: 8];
        if (velocity_mode_reg)
        begin
            result.velocity = (vel_div == 7'd0) ? 7'd0 : vel_div - 7'd1;
        end
        else
        begin
            result.velocity = FIXED_VELOCITY;
        end
    end

    // Output queue
    dpt_out_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] head_reg;
    logic [FIFO_PW-1:0] head_next;
    logic [FIFO_PW-1:0] tail_reg;
    logic [FIFO_PW-1:0] tail_next;
    logic [FIFO_PW-1:0] cnt_reg;
    logic [FIFO_PW-1:0] cnt_next;
    logic               pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign out_data  = fifo_mem[head_reg];
    // Leave room for the item in the update stage and the one being accepted
    assign in_ready  = ({1'b0, cnt_reg} + {{FIFO_PW{1'b0}}, s1_vld_reg})
                       < (FIFO_PW+1)'(FIFO_DEPTH);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            head_next = (head_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                : head_reg + FIFO_PW'(1);
        end
        if (emit)
        begin
            tail_next = (tail_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                : tail_reg + FIFO_PW'(1);
        end
        if (emit && !pop)
        begin
            cnt_next = cnt_reg + FIFO_PW'(1);
        end
        else if (pop && !emit)
        begin
            cnt_next = cnt_reg - FIFO_PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            fifo_mem[tail_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && !pop && (cnt_reg == FIFO_PW'(FIFO_DEPTH))))
        else $error("note-on pushed into a full output queue");

    a_hit_arms_pad: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (fwd_vld_reg && fwd_data_reg.active && (fwd_data_reg.count == '0)))
        else $error("note-on did not arm the pad with a cleared count");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} + {{FIFO_PW{1'b0}}, s1_vld_reg}) <= (FIFO_PW+1)'(FIFO_DEPTH))
        else $error("items in flight exceed output queue space");
`endif

endmodule
`default_nettype wire
